FILE: src/glmd_pkg.sv
// ---------------------------------------------------------------------------
// glmd_pkg - shared definitions for the grid local minimum detector
// Widths, reset values, register indexes and word commands.
// ---------------------------------------------------------------------------
package glmd_pkg;

    // default line store depth, cells per row at most
    localparam int MAX_WIDTH_DEF = 128;

    // field widths
    localparam int LEVEL_W = 4;
    localparam int GW_W    = 8;
    localparam int GR_W    = 11;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 10;
    localparam int COUNT_W = 18;

    // configuration reset values and limits
    localparam logic [GW_W-1:0] GRID_WIDTH_RST = 8'd100;
    localparam logic [GR_W-1:0] GRID_ROWS_RST  = 11'd100;
    localparam logic [GR_W-1:0] ROWS_MIN       = 11'd2;
    localparam logic [GR_W-1:0] ROWS_LIMIT     = 11'd1024;

    // register indexes on the configuration port
    localparam logic REG_GRID_WIDTH = 1'b0;
    localparam logic REG_GRID_ROWS  = 1'b1;

    // word commands
    localparam logic CMD_CELL = 1'b0;
    localparam logic CMD_PAD  = 1'b1;

    typedef logic [LEVEL_W-1:0] t_level;

endpackage

FILE: src/glmd_cell.sv
// ---------------------------------------------------------------------------
// glmd_cell - one column cell of the line stores
// Holds the middle and upper line entries and passes them on at each word.
// ---------------------------------------------------------------------------
module glmd_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  glmd_pkg::t_level i_mid,
    input  glmd_pkg::t_level i_up,
    output glmd_pkg::t_level o_mid,
    output glmd_pkg::t_level o_up
);

    glmd_pkg::t_level r_mid;
    glmd_pkg::t_level r_up;

    // shift both lines one place on every accepted word
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_mid <= i_mid;
            r_up  <= i_up;
        end
    end

    assign o_mid = r_mid;
    assign o_up  = r_up;

endmodule

FILE: src/glmd_line.sv
// ---------------------------------------------------------------------------
// glmd_line - chain of cells forming the two line delays
// The middle line delays the incoming level by one row, the upper line
// delays the middle line output by one more row; the row length is a tap.
// ---------------------------------------------------------------------------
module glmd_line #(
    parameter int P_DEPTH = glmd_pkg::MAX_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [$clog2(P_DEPTH)-1:0] i_tap_sel,
    input  glmd_pkg::t_level           i_level,
    output glmd_pkg::t_level           o_mid_tap,
    output glmd_pkg::t_level           o_up_tap
);

    glmd_pkg::t_level mid_q [P_DEPTH];
    glmd_pkg::t_level up_q  [P_DEPTH];

    // row of cells, each fed by its left neighbor
    genvar k;
    generate
        for (k = 0; k < P_DEPTH; k++) begin : g_cell
            glmd_pkg::t_level mid_d;
            glmd_pkg::t_level up_d;
            if (k == 0) begin : g_head
                assign mid_d = i_level;
                assign up_d  = o_mid_tap;
            end else begin : g_body
                assign mid_d = mid_q[k-1];
                assign up_d  = up_q[k-1];
            end
            glmd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_shift),
                .i_mid   (mid_d),
                .i_up    (up_d),
                .o_mid   (mid_q[k]),
                .o_up    (up_q[k])
            );
        end
    endgenerate

    // taps at the end of the active row length
    assign o_mid_tap = mid_q[i_tap_sel];
    assign o_up_tap  = up_q[i_tap_sel];

endmodule

FILE: src/grid_local_minimum_detector.sv
// ---------------------------------------------------------------------------
// grid_local_minimum_detector - 3x3 local minimum detector over a raster
// Marks each cell strictly below all existing 8-neighbours, with a
// running count of low cells per frame.
// ---------------------------------------------------------------------------
// Usage:
//   Input words (i_valid / o_stall) carry one raster cell each in row-major
//   order, or a padding word (command 1) that enters as level 0. After the
//   frame's last cell, grid_width+1 padding words flush the last results.
//   Result words (o_valid / i_stall) carry the position, level, low flag,
//   running low count and frame_done of one cell.
//   Throughput is one word per cycle while o_stall is low. A cell is
//   reported on the word that arrives grid_width+1 words after it, and the
//   result appears in the output register in the cycle after that word is
//   accepted; the first grid_width+1 words of each frame give no result.
//   When the receiver stalls, the held result stays on the outputs and
//   o_stall rises, so no input word is taken until the result leaves.
//   Reset clears the position, the count and the output valid flag and sets
//   grid_width and grid_rows to 100. The line stores are not cleared; their
//   stale entries only fall on clipped neighbours. Any register write
//   restarts the frame.
// ---------------------------------------------------------------------------
module grid_local_minimum_detector #(
    parameter int P_MAX_WIDTH = glmd_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input words
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [glmd_pkg::LEVEL_W-1:0]  i_cell_level,
    // result words
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [glmd_pkg::COL_W-1:0]    o_cell_col,
    output logic [glmd_pkg::ROW_W-1:0]    o_cell_row,
    output logic [glmd_pkg::LEVEL_W-1:0]  o_reported_level,
    output logic                          o_is_low,
    output logic [glmd_pkg::COUNT_W-1:0]  o_low_count,
    output logic                          o_frame_done,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int CW = $clog2(P_MAX_WIDTH);
    localparam int EW = (CW + 1 > glmd_pkg::GW_W) ? CW + 1 : glmd_pkg::GW_W;
    localparam int GR = glmd_pkg::GR_W;

    // configuration registers
    logic [glmd_pkg::GW_W-1:0] r_grid_width;
    logic [GR-1:0]             r_grid_rows;
    logic                      cfg_wr;

    // position and count
    logic [CW-1:0]                r_col, n_col;
    logic [GR-1:0]                r_row, n_row;
    logic [glmd_pkg::COUNT_W-1:0] r_low_cnt, n_low_cnt;

    // window, indexed as three rows of three columns
    glmd_pkg::t_level r_win [9];
    glmd_pkg::t_level n_win [9];

    // output register
    logic                         r_out_valid;
    logic [glmd_pkg::COL_W-1:0]   r_out_col;
    logic [glmd_pkg::ROW_W-1:0]   r_out_row;
    glmd_pkg::t_level             r_out_level;
    logic                         r_out_low;
    logic [glmd_pkg::COUNT_W-1:0] r_out_count;
    logic                         r_out_done;

    logic             in_acc;
    logic [EW-1:0]    eff_w;
    logic [EW-1:0]    gw_ext;
    logic [GR-1:0]    eff_h;
    logic [CW-1:0]    tap_sel;
    logic [CW-1:0]    c_use;
    logic [EW-1:0]    c_next_ext;
    glmd_pkg::t_level lvl_in;
    glmd_pkg::t_level mid_tap;
    glmd_pkg::t_level up_tap;
    logic             have;
    logic [GR-1:0]    cr;
    logic [CW-1:0]    cc;
    logic             res_valid;
    logic             res_low;
    logic             res_done;
    logic             top_ok, bot_ok, left_ok, right_ok;
    glmd_pkg::t_level centre;

    // handshakes
    assign o_stall = r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    // effective width and row count, clamped to their legal ranges
    always_comb begin
        gw_ext = EW'(r_grid_width);
        if (gw_ext < EW'(2)) begin
            eff_w = EW'(2);
        end else if (gw_ext > EW'(P_MAX_WIDTH)) begin
            eff_w = EW'(P_MAX_WIDTH);
        end else begin
            eff_w = gw_ext;
        end
        if (r_grid_rows < glmd_pkg::ROWS_MIN) begin
            eff_h = glmd_pkg::ROWS_MIN;
        end else if (r_grid_rows > glmd_pkg::ROWS_LIMIT) begin
            eff_h = glmd_pkg::ROWS_LIMIT;
        end else begin
            eff_h = r_grid_rows;
        end
    end

    assign tap_sel = CW'(eff_w - EW'(1));
    assign lvl_in  = (i_command == glmd_pkg::CMD_PAD) ? '0 : i_cell_level;

    // line stores
    glmd_line #(
        .P_DEPTH (P_MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_shift   (in_acc),
        .i_tap_sel (tap_sel),
        .i_level   (lvl_in),
        .o_mid_tap (mid_tap),
        .o_up_tap  (up_tap)
    );

    // window shift, centre position, neighbour test and position advance
    always_comb begin
        c_use = (EW'(r_col) >= eff_w) ? '0 : r_col;

        for (int k = 0; k < 3; k++) begin
            n_win[k*3]     = r_win[k*3+1];
            n_win[k*3 + 1] = r_win[k*3+2];
        end
        n_win[2] = up_tap;
        n_win[5] = mid_tap;
        n_win[8] = lvl_in;
        centre   = n_win[4];

        if (c_use != '0) begin
            have = (r_row >= GR'(1));
            cr   = r_row - GR'(1);
            cc   = c_use - CW'(1);
        end else begin
            have = (r_row >= GR'(2));
            cr   = r_row - GR'(2);
            cc   = tap_sel;
        end
        res_valid = have && (cr < eff_h);

        top_ok   = (cr != '0);
        bot_ok   = (cr != eff_h - GR'(1));
        left_ok  = (cc != '0);
        right_ok = (cc != tap_sel);

        res_low = 1'b1;
        for (int k = 0; k < 9; k++) begin
            if (k != 4
                && !(k / 3 == 0 && !top_ok) && !(k / 3 == 2 && !bot_ok)
                && !(k % 3 == 0 && !left_ok) && !(k % 3 == 2 && !right_ok)
                && !(centre < n_win[k])) begin
                res_low = 1'b0;
            end
        end
        res_done = bot_ok == 1'b0 && right_ok == 1'b0;

        // saturating low count
        n_low_cnt = r_low_cnt;
        if (res_valid && res_low && r_low_cnt != '1) begin
            n_low_cnt = r_low_cnt + glmd_pkg::COUNT_W'(1);
        end

        c_next_ext = EW'(c_use) + EW'(1);
        if (c_next_ext >= eff_w) begin
            n_col = '0;
            n_row = r_row + GR'(1);
        end else begin
            n_col = CW'(c_next_ext);
            n_row = r_row;
        end
    end

    // configuration registers and readback
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= glmd_pkg::GRID_WIDTH_RST;
            r_grid_rows  <= glmd_pkg::GRID_ROWS_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                glmd_pkg::REG_GRID_WIDTH: r_grid_width <= pwdata[glmd_pkg::GW_W-1:0];
                glmd_pkg::REG_GRID_ROWS:  r_grid_rows  <= pwdata[GR-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            glmd_pkg::REG_GRID_WIDTH: prdata = 32'(r_grid_width);
            glmd_pkg::REG_GRID_ROWS:  prdata = 32'(r_grid_rows);
            default:                  prdata = '0;
        endcase
    end

    // position and count, restarted by a register write or at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_low_cnt <= '0;
        end else if (cfg_wr || (in_acc && res_valid && res_done)) begin
            r_col     <= '0;
            r_row     <= '0;
            r_low_cnt <= '0;
        end else if (in_acc) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_low_cnt <= n_low_cnt;
        end
    end

    // window cells
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= res_valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            r_out_col   <= glmd_pkg::COL_W'(cc);
            r_out_row   <= cr[glmd_pkg::ROW_W-1:0];
            r_out_level <= centre;
            r_out_low   <= res_low;
            r_out_count <= n_low_cnt;
            r_out_done  <= res_done;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_cell_col       = r_out_col;
    assign o_cell_row       = r_out_row;
    assign o_reported_level = r_out_level;
    assign o_is_low         = r_out_low;
    assign o_low_count      = r_out_count;
    assign o_frame_done     = r_out_done;

    // column position always stays inside the active row
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_col) < eff_w)
        else $error("column position beyond row width");

    // frame end restarts the position
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && res_valid && res_done) |=> (r_col == '0 && r_row == '0))
        else $error("position not restarted after frame end");

    // a low cell is always counted
    a_low_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_low) |-> (o_low_count != '0))
        else $error("low cell reported with zero count");

endmodule
